[hw/rtl/leg_foot_trajectory_generator_defines.svh]
// Assertion macros shared by the foot trajectory generator RTL.
`ifndef LEG_FOOT_TRAJECTORY_GENERATOR_DEFINES_SVH
`define LEG_FOOT_TRAJECTORY_GENERATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define LFTG_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lftg: check failed");
`define LFTG_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lftg: check failed");
`else
`define LFTG_ASSERT_IMPL(label, ante, cons)
`define LFTG_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[hw/rtl/lftg_pkg.sv]
// Types, constants and helper functions of the foot trajectory generator.
package lftg_pkg;

	localparam int LEN_W   = 24;
	localparam int TIME_W  = 24;
	localparam int ANG_W   = 16;
	localparam int DUTY_W  = 16;
	localparam int DH_W    = 20;
	localparam int DIVS_W  = 16;
	localparam int STR_W   = LEN_W - 1;
	localparam int TT_W    = TIME_W + DUTY_W;
	localparam int NUM_W   = TT_W + ANG_W - 1;
	localparam int REM_W   = TT_W + 2;
	localparam int QUO_W   = STR_W;
	localparam int CNT_W   = $clog2(NUM_W + 1);
	localparam int CS_W    = 33;
	localparam int CORDIC_STEPS = 20;
	localparam int IT_W    = 5;
	localparam int MOP_W   = 34;
	localparam int PROD_W  = 2 * MOP_W;
	localparam int SUM_W   = 48;
	localparam int CFG_W   = 24;
	localparam int IDX_W   = 3;
	localparam int IN_W    = 128;
	localparam int OUT_W   = 3 * LEN_W;
	localparam int USER_W  = 2;

	localparam logic signed [SUM_W-1:0] FAR_EDGE = SUM_W'(62915);
	localparam logic signed [CS_W-1:0] CORDIC_GAIN = CS_W'(652032874);
	localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((64'sd1 <<< (LEN_W - 1)) - 64'sd1);
	localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

	typedef enum logic [IDX_W-1:0] {
		REG_DUTY, REG_STEP_H, REG_OFF_X, REG_OFF_Y, REG_OFF_Z, REG_MOUNT
	} reg_idx_t;

	typedef enum logic [2:0] {
		MUL_DT, MUL_END, MUL_SWX, MUL_SWZ, MUL_ROTX, MUL_ROTY
	} mul_sel_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_PREP, ST_TEST, ST_ENDT, ST_DIV, ST_STX, ST_CLD1, ST_CW1,
		ST_MX, ST_MZ, ST_SWZ, ST_CLD2, ST_CW2, ST_RX, ST_RY, ST_RZ, ST_OUT
	} state_t;

	typedef struct packed {
		logic     load_in;
		logic     first_init;
		mul_sel_t mul_sel;
		logic     cap_test;
		logic     cap_end;
		logic     div_step;
		logic     cap_stx;
		logic     cord_load;
		logic     cord_rot;
		logic     cord_step;
		logic     cap_swx;
		logic     cap_swz;
		logic     cap_fx;
		logic     cap_fyz;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic stance;
		logic den_zero;
		logic div_last;
		logic cord_last;
		logic out_busy;
	} stat_t;

	function automatic logic signed [CS_W-1:0] atan_lut(input logic [IT_W-1:0] i);
		logic signed [CS_W-1:0] v;
		case (i)
			5'd0:    v = CS_W'(32'h20000000);
			5'd1:    v = CS_W'(32'h12E4051E);
			5'd2:    v = CS_W'(32'h09FB385B);
			5'd3:    v = CS_W'(32'h051111D4);
			5'd4:    v = CS_W'(32'h028B0D43);
			5'd5:    v = CS_W'(32'h0145D7E1);
			5'd6:    v = CS_W'(32'h00A2F61E);
			5'd7:    v = CS_W'(32'h00517C55);
			5'd8:    v = CS_W'(32'h0028BE53);
			5'd9:    v = CS_W'(32'h00145F2F);
			5'd10:   v = CS_W'(32'h000A2F98);
			5'd11:   v = CS_W'(32'h000517CC);
			5'd12:   v = CS_W'(32'h00028BE6);
			5'd13:   v = CS_W'(32'h000145F3);
			5'd14:   v = CS_W'(32'h0000A2FA);
			5'd15:   v = CS_W'(32'h0000517D);
			5'd16:   v = CS_W'(32'h000028BE);
			5'd17:   v = CS_W'(32'h0000145F);
			5'd18:   v = CS_W'(32'h00000A30);
			5'd19:   v = CS_W'(32'h00000518);
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic logic signed [LEN_W-1:0] sat_len(input logic signed [SUM_W-1:0] v);
		logic signed [LEN_W-1:0] r;
		if (v > SAT_HI)
			r = SAT_HI[LEN_W-1:0];
		else if (v < SAT_LO)
			r = SAT_LO[LEN_W-1:0];
		else
			r = v[LEN_W-1:0];
		return r;
	endfunction

endpackage

[hw/rtl/lftg_dp.sv]
// Datapath: config registers, gait state, shared multiplier, serial divider, CORDIC, output.
module lftg_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lftg_pkg::cmd_t                cmd,
	output lftg_pkg::stat_t               stat,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lftg_pkg::IDX_W-1:0]    cfg_index,
	input  logic [lftg_pkg::CFG_W-1:0]    cfg_data,
	input  logic [lftg_pkg::IN_W-1:0]     s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [lftg_pkg::OUT_W-1:0]    m_tdata,
	output logic [lftg_pkg::USER_W-1:0]   m_tuser
);
	localparam int LEN_W  = lftg_pkg::LEN_W;
	localparam int TIME_W = lftg_pkg::TIME_W;
	localparam int ANG_W  = lftg_pkg::ANG_W;
	localparam int STR_W  = lftg_pkg::STR_W;
	localparam int TT_W   = lftg_pkg::TT_W;
	localparam int NUM_W  = lftg_pkg::NUM_W;
	localparam int REM_W  = lftg_pkg::REM_W;
	localparam int QUO_W  = lftg_pkg::QUO_W;
	localparam int CNT_W  = lftg_pkg::CNT_W;
	localparam int CS_W   = lftg_pkg::CS_W;
	localparam int IT_W   = lftg_pkg::IT_W;
	localparam int MOP_W  = lftg_pkg::MOP_W;
	localparam int PROD_W = lftg_pkg::PROD_W;
	localparam int SUM_W  = lftg_pkg::SUM_W;
	localparam int DUTY_W = lftg_pkg::DUTY_W;
	localparam int DH_W   = lftg_pkg::DH_W;
	localparam int DIVS_W = lftg_pkg::DIVS_W;

	localparam int O_DIVS  = TIME_W;
	localparam int O_T     = O_DIVS + DIVS_W;
	localparam int O_L     = O_T + TIME_W;
	localparam int O_FIRST = O_L + STR_W;
	localparam int O_HD    = O_FIRST + STR_W;

	localparam logic signed [MOP_W-1:0]  ONE_Q30 = MOP_W'(64'sd1 <<< 30);
	localparam logic signed [PROD_W-1:0] RND31   = PROD_W'(64'sd1 <<< 30);
	localparam logic signed [PROD_W-1:0] RND30   = PROD_W'(64'sd1 <<< 29);

	// configuration
	logic [DUTY_W-1:0]       duty_q;
	logic [DH_W-1:0]         dh_q;
	logic signed [LEN_W-1:0] offx_q, offy_q, offz_q;
	logic [ANG_W-1:0]        mnt_q;

	// item and gait state
	logic [TIME_W-1:0]       per_q, t_q;
	logic [DIVS_W-1:0]       divs_q;
	logic [STR_W-1:0]        l_q, first_q, sup_q;
	logic [ANG_W-1:0]        hd_q;
	logic                    started_q;
	logic signed [LEN_W-1:0] tex_q;
	logic [TT_W-1:0]         dt_q;
	logic                    swing_q, end_hit_q;
	logic signed [LEN_W-1:0] x0_q, z0_q, fx_q, fy_q, fz_q;

	// multiplier
	logic signed [MOP_W-1:0]  ma, mb;
	logic signed [PROD_W-1:0] prod_q;

	// divider
	logic [NUM_W-1:0] a_q;
	logic [TT_W-1:0]  b_q, d_q, r_q;
	logic [QUO_W-1:0] q_q;
	logic [CNT_W-1:0] cnt_q;

	// cordic
	logic signed [CS_W-1:0] x_q, y_q, z_q;
	logic [IT_W-1:0]        it_q;
	logic                   neg_q;

	// output
	logic                    ovalid_q;
	logic [lftg_pkg::OUT_W-1:0]  odata_q;
	logic [lftg_pkg::USER_W-1:0] ouser_q;

	logic [TT_W-1:0]        tt, num, den;
	logic [TIME_W-1:0]      t_gap;
	logic [ANG_W-1:0]       cang;
	logic [31:0]            u;
	logic                   flip;
	logic signed [CS_W-1:0] c_val, s_val, sh_x, sh_y, atan_i;
	logic [TT_W-1:0]        addv;
	logic [REM_W-1:0]       r1, r2, r3, dd;
	logic                   ge1, ge2;
	logic signed [PROD_W-1:0] rnd31_v, rnd30_v;

	assign tt    = {t_q, {DUTY_W{1'b0}}};
	assign num   = tt - dt_q;
	assign den   = {per_q, {DUTY_W{1'b0}}} - dt_q;
	assign t_gap = (t_q > per_q) ? t_q - per_q : per_q - t_q;

	assign stat.stance    = !swing_q;
	assign stat.den_zero  = (den == '0);
	assign stat.div_last  = (cnt_q == CNT_W'(1));
	assign stat.cord_last = (it_q == IT_W'(lftg_pkg::CORDIC_STEPS - 1));
	assign stat.out_busy  = ovalid_q && !m_tready;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_q <= DUTY_W'(49152);
			dh_q   <= '0;
			offx_q <= '0;
			offy_q <= '0;
			offz_q <= '0;
			mnt_q  <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				lftg_pkg::REG_DUTY:   duty_q <= cfg_data[DUTY_W-1:0];
				lftg_pkg::REG_STEP_H: dh_q   <= cfg_data[DH_W-1:0];
				lftg_pkg::REG_OFF_X:  offx_q <= cfg_data[LEN_W-1:0];
				lftg_pkg::REG_OFF_Y:  offy_q <= cfg_data[LEN_W-1:0];
				lftg_pkg::REG_OFF_Z:  offz_q <= cfg_data[LEN_W-1:0];
				lftg_pkg::REG_MOUNT:  mnt_q  <= cfg_data[ANG_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			per_q   <= s_tdata[O_DIVS-1:0];
			divs_q  <= s_tdata[O_T-1:O_DIVS];
			t_q     <= s_tdata[O_L-1:O_T];
			l_q     <= s_tdata[O_FIRST-1:O_L];
			first_q <= s_tdata[O_HD-1:O_FIRST];
			hd_q    <= s_tdata[O_HD+ANG_W-1:O_HD];
		end
	end

	// gait state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			sup_q     <= '0;
			tex_q     <= '0;
		end else if (cmd.first_init && !started_q) begin
			started_q <= 1'b1;
			sup_q     <= first_q;
			tex_q     <= lftg_pkg::sat_len(SUM_W'(offy_q) - lftg_pkg::FAR_EDGE
				- SUM_W'(first_q));
		end else if (cmd.cap_swz && end_hit_q) begin
			sup_q <= l_q;
			tex_q <= x0_q;
		end
	end

	// shared multiplier
	always_comb begin
		ma = '0;
		mb = '0;
		unique case (cmd.mul_sel)
			lftg_pkg::MUL_DT: begin
				ma = MOP_W'(duty_q);
				mb = MOP_W'(per_q);
			end
			lftg_pkg::MUL_END: begin
				ma = MOP_W'(t_gap);
				mb = MOP_W'(divs_q);
			end
			lftg_pkg::MUL_SWX: begin
				ma = MOP_W'(l_q);
				mb = MOP_W'(c_val) + ONE_Q30;
			end
			lftg_pkg::MUL_SWZ: begin
				ma = MOP_W'(dh_q);
				mb = MOP_W'(s_val);
			end
			lftg_pkg::MUL_ROTX: begin
				ma = MOP_W'(x0_q);
				mb = MOP_W'(c_val);
			end
			lftg_pkg::MUL_ROTY: begin
				ma = MOP_W'(x0_q);
				mb = MOP_W'(s_val);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= ma * mb;
	end

	assign rnd31_v = (prod_q + RND31) >>> 31;
	assign rnd30_v = (prod_q + RND30) >>> 30;

	always_ff @(posedge clk) begin
		if (cmd.cap_test) begin
			dt_q    <= prod_q[TT_W-1:0];
			swing_q <= !(tt < prod_q[TT_W-1:0]);
		end
		if (cmd.cap_end)
			end_hit_q <= swing_q && (prod_q[TT_W-1:0] < TT_W'(per_q));
		if (cmd.cap_stx) begin
			x0_q <= lftg_pkg::sat_len(SUM_W'(tex_q) + SUM_W'(q_q));
			z0_q <= '0;
		end
		if (cmd.cap_swx)
			x0_q <= lftg_pkg::sat_len(SUM_W'(tex_q) + rnd31_v[SUM_W-1:0]);
		if (cmd.cap_swz)
			z0_q <= lftg_pkg::sat_len(rnd30_v[SUM_W-1:0]);
		if (cmd.cap_fx)
			fx_q <= lftg_pkg::sat_len(SUM_W'(offx_q) + rnd30_v[SUM_W-1:0]);
		if (cmd.cap_fyz) begin
			fy_q <= lftg_pkg::sat_len(SUM_W'(offy_q) + rnd30_v[SUM_W-1:0]);
			fz_q <= lftg_pkg::sat_len(SUM_W'(offz_q) + SUM_W'(z0_q));
		end
	end

	// serial multiply-divide: r = 2r + bit*b, reduced by d up to twice
	assign addv = a_q[NUM_W-1] ? b_q : '0;
	assign dd   = REM_W'(d_q);
	assign r1   = {1'b0, r_q, 1'b0} + REM_W'(addv);
	assign ge1  = (r1 >= dd);
	assign r2   = ge1 ? r1 - dd : r1;
	assign ge2  = (r2 >= dd);
	assign r3   = ge2 ? r2 - dd : r2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.cap_end) begin
			cnt_q <= swing_q ? CNT_W'(NUM_W) : CNT_W'(STR_W);
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_end) begin
			r_q <= '0;
			q_q <= '0;
			if (swing_q) begin
				a_q <= {num, {(ANG_W-1){1'b0}}};
				b_q <= TT_W'(1);
				d_q <= den;
			end else begin
				a_q <= {sup_q, {(NUM_W-STR_W){1'b0}}};
				b_q <= tt;
				d_q <= dt_q;
			end
		end else if (cmd.div_step) begin
			a_q <= {a_q[NUM_W-2:0], 1'b0};
			r_q <= r3[TT_W-1:0];
			q_q <= {q_q[QUO_W-2:0], 1'b0} + QUO_W'(ge1) + QUO_W'(ge2);
		end
	end

	// cordic rotation, one step a cycle
	assign cang   = cmd.cord_rot ? mnt_q + hd_q : q_q[ANG_W-1:0];
	assign u      = {cang, {(32-ANG_W){1'b0}}};
	assign flip   = u[31] ^ u[30];
	assign sh_x   = x_q >>> it_q;
	assign sh_y   = y_q >>> it_q;
	assign atan_i = lftg_pkg::atan_lut(it_q);
	assign c_val  = neg_q ? -x_q : x_q;
	assign s_val  = neg_q ? -y_q : y_q;

	always_ff @(posedge clk) begin
		if (cmd.cord_load) begin
			x_q   <= lftg_pkg::CORDIC_GAIN;
			y_q   <= '0;
			z_q   <= {u[31] ^ flip, u[31] ^ flip, u[30:0]};
			neg_q <= flip;
			it_q  <= '0;
		end else if (cmd.cord_step) begin
			if (!z_q[CS_W-1]) begin
				x_q <= x_q - sh_y;
				y_q <= y_q + sh_x;
				z_q <= z_q - atan_i;
			end else begin
				x_q <= x_q + sh_y;
				y_q <= y_q - sh_x;
				z_q <= z_q + atan_i;
			end
			it_q <= it_q + IT_W'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ovalid_q <= 1'b0;
		else if (cmd.out_load)
			ovalid_q <= 1'b1;
		else if (m_tready)
			ovalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			odata_q <= {fz_q, fy_q, fx_q};
			ouser_q <= {end_hit_q, swing_q};
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata  = odata_q;
	assign m_tuser  = ouser_q;

endmodule

[hw/rtl/lftg_ctrl.sv]
// Controller state machine sequencing the datapath for one sample.
`include "leg_foot_trajectory_generator_defines.svh"
module lftg_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  lftg_pkg::stat_t  stat,
	output lftg_pkg::cmd_t   cmd
);
	lftg_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= lftg_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			lftg_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_d     = lftg_pkg::ST_PREP;
				end
			end
			lftg_pkg::ST_PREP: begin
				cmd.first_init = 1'b1;
				cmd.mul_sel    = lftg_pkg::MUL_DT;
				state_d        = lftg_pkg::ST_TEST;
			end
			lftg_pkg::ST_TEST: begin
				cmd.cap_test = 1'b1;
				cmd.mul_sel  = lftg_pkg::MUL_END;
				state_d      = lftg_pkg::ST_ENDT;
			end
			lftg_pkg::ST_ENDT: begin
				cmd.cap_end = 1'b1;
				if (!stat.stance && stat.den_zero)
					state_d = lftg_pkg::ST_CLD1;
				else
					state_d = lftg_pkg::ST_DIV;
			end
			lftg_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last)
					state_d = stat.stance ? lftg_pkg::ST_STX : lftg_pkg::ST_CLD1;
			end
			lftg_pkg::ST_STX: begin
				cmd.cap_stx = 1'b1;
				state_d     = lftg_pkg::ST_CLD2;
			end
			lftg_pkg::ST_CLD1: begin
				cmd.cord_load = 1'b1;
				state_d       = lftg_pkg::ST_CW1;
			end
			lftg_pkg::ST_CW1: begin
				cmd.cord_step = 1'b1;
				if (stat.cord_last)
					state_d = lftg_pkg::ST_MX;
			end
			lftg_pkg::ST_MX: begin
				cmd.mul_sel = lftg_pkg::MUL_SWX;
				state_d     = lftg_pkg::ST_MZ;
			end
			lftg_pkg::ST_MZ: begin
				cmd.cap_swx = 1'b1;
				cmd.mul_sel = lftg_pkg::MUL_SWZ;
				state_d     = lftg_pkg::ST_SWZ;
			end
			lftg_pkg::ST_SWZ: begin
				cmd.cap_swz = 1'b1;
				state_d     = lftg_pkg::ST_CLD2;
			end
			lftg_pkg::ST_CLD2: begin
				cmd.cord_load = 1'b1;
				cmd.cord_rot  = 1'b1;
				state_d       = lftg_pkg::ST_CW2;
			end
			lftg_pkg::ST_CW2: begin
				cmd.cord_step = 1'b1;
				if (stat.cord_last)
					state_d = lftg_pkg::ST_RX;
			end
			lftg_pkg::ST_RX: begin
				cmd.mul_sel = lftg_pkg::MUL_ROTX;
				state_d     = lftg_pkg::ST_RY;
			end
			lftg_pkg::ST_RY: begin
				cmd.cap_fx  = 1'b1;
				cmd.mul_sel = lftg_pkg::MUL_ROTY;
				state_d     = lftg_pkg::ST_RZ;
			end
			lftg_pkg::ST_RZ: begin
				cmd.cap_fyz = 1'b1;
				state_d     = lftg_pkg::ST_OUT;
			end
			lftg_pkg::ST_OUT: begin
				if (!stat.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = lftg_pkg::ST_IDLE;
				end
			end
			default: state_d = lftg_pkg::ST_IDLE;
		endcase
	end

	`LFTG_ASSERT_NEXT(a_out_then_idle, cmd.out_load, state_q == lftg_pkg::ST_IDLE)
	`LFTG_ASSERT_NEXT(a_flat_swing_skips_div, state_q == lftg_pkg::ST_ENDT && !stat.stance && stat.den_zero, state_q == lftg_pkg::ST_CLD1)
	`LFTG_ASSERT_IMPL(a_no_load_while_busy, state_q == lftg_pkg::ST_OUT && stat.out_busy, !cmd.out_load && !s_tready)

endmodule

[hw/rtl/leg_foot_trajectory_generator.sv]
// Top level of the leg foot trajectory generator.
//
//  channel  direction  payload (low bit first)
//  s_*      in         cycle_period, divisions, phase_time, swing_stride, first_stride, heading
//  m_*      out        tdata: foot_x, foot_y, foot_z; tuser: in_swing, swing_ended
//  cfg_*    in         cfg_index selects the register, cfg_data holds the value
//
// A stance sample runs the serial divider (23 steps) and one 20-step CORDIC run; a swing
// sample runs the divider (55 steps) and two CORDIC runs on one shared unit, and one
// with a zero-length swing period skips the divider. One sample is in flight at a time;
// a finished result waits in the output register while the next sample is taken, and a
// stalled output holds the controller before its load. Reset clears gait state and
// loads register defaults.
module leg_foot_trajectory_generator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// cycle_period, divisions, phase_time, swing_stride, first_stride, heading, zero pad
	input  logic [lftg_pkg::IN_W-1:0]     s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// foot_x, foot_y, foot_z
	output logic [lftg_pkg::OUT_W-1:0]    m_tdata,
	// in_swing, swing_ended
	output logic [lftg_pkg::USER_W-1:0]   m_tuser,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lftg_pkg::IDX_W-1:0]    cfg_index,
	input  logic [lftg_pkg::CFG_W-1:0]    cfg_data
);
	lftg_pkg::cmd_t  cmd;
	lftg_pkg::stat_t stat;

	lftg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	lftg_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule
